// ===== rtl/pdau_pkg.sv =====
// shared types, register codes and saturation helper for the pid unit
// no dependencies
package pdau_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_GAIN_PROP     = 3'd0,
        REG_GAIN_INTEGRAL = 3'd1,
        REG_GAIN_DERIV    = 3'd2,
        REG_DERIV_COEF    = 3'd3,
        REG_DEADBAND_HIGH = 3'd4,
        REG_DEADBAND_LOW  = 3'd5,
        REG_LIMIT_HIGH    = 3'd6,
        REG_LIMIT_LOW     = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        LIM_WITHIN = 2'd0,
        LIM_HIGH   = 2'd1,
        LIM_LOW    = 2'd2
    } limit_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_P,
        ST_I1,
        ST_I2,
        ST_IACC,
        ST_DM,
        ST_DDIFF,
        ST_D,
        ST_F,
        ST_FACC,
        ST_SUM,
        ST_CLAMP
    } seq_state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] gain_prop;
        logic signed [DATA_W-1:0] gain_integral;
        logic signed [DATA_W-1:0] gain_deriv;
        logic [DATA_W-2:0]        deriv_filter_coef;
        logic signed [DATA_W-1:0] deadband_high;
        logic signed [DATA_W-1:0] deadband_low;
        logic signed [DATA_W-1:0] limit_high;
        logic signed [DATA_W-1:0] limit_low;
    } cfg_t;

    // saturate a 34-bit signed sum to 32 bits
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/pdau_mul.sv =====
// bit-serial signed multiplier, one multiplier bit per cycle
// floor shift by the fraction width and saturation to 32 bits; uses pdau_pkg
module pdau_mul
    import pdau_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic                     done,
    output logic signed [DATA_W-1:0] result
);
    localparam int CNT_W = $clog2(DATA_W);

    logic                     busy_reg, busy_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [DATA_W+1:0] hi_reg, hi_next;
    logic [DATA_W-1:0]        lo_reg, lo_next;
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W+1:0] addend;
    logic signed [DATA_W+1:0] sum;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W-1:0] shifted;
    logic                     last;

    assign last = (cnt_reg == CNT_W'(DATA_W - 1));

    always_comb
    begin
        // last multiplier bit carries negative weight
        if (!lo_reg[0])
            addend = '0;
        else if (last)
            addend = -{{2{a_reg[DATA_W-1]}}, a_reg};
        else
            addend = {{2{a_reg[DATA_W-1]}}, a_reg};
        sum = hi_reg + addend;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = op_b;
            a_next    = op_a;
        end
        else if (busy_reg)
        begin
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[DATA_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign prod    = {hi_reg[DATA_W-1:0], lo_reg};
    assign shifted = prod >>> FRAC_BITS;
    assign done    = done_reg;

    always_comb
    begin
        if (!shifted[2*DATA_W-1] && (|shifted[2*DATA_W-2:DATA_W-1]))
            result = 32'sh7FFF_FFFF;
        else if (shifted[2*DATA_W-1] && !(&shifted[2*DATA_W-2:DATA_W-1]))
            result = 32'sh8000_0000;
        else
            result = shifted[DATA_W-1:0];
    end
endmodule

// ===== rtl/pdau_cfg.sv =====
// apb register file holding gains, derivative filter coefficient, dead band and output limits
// uses pdau_pkg
module pdau_cfg
    import pdau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);
    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop         <= 32'sd65536;
            cfg_reg.gain_integral     <= '0;
            cfg_reg.gain_deriv        <= '0;
            cfg_reg.deriv_filter_coef <= 31'd65536;
            cfg_reg.deadband_high     <= '0;
            cfg_reg.deadband_low      <= '0;
            cfg_reg.limit_high        <= 32'sd6553600;
            cfg_reg.limit_low         <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_GAIN_PROP:     cfg_reg.gain_prop         <= pwdata;
                REG_GAIN_INTEGRAL: cfg_reg.gain_integral     <= pwdata;
                REG_GAIN_DERIV:    cfg_reg.gain_deriv        <= pwdata;
                REG_DERIV_COEF:    cfg_reg.deriv_filter_coef <= pwdata[DATA_W-2:0];
                REG_DEADBAND_HIGH: cfg_reg.deadband_high     <= pwdata;
                REG_DEADBAND_LOW:  cfg_reg.deadband_low      <= pwdata;
                REG_LIMIT_HIGH:    cfg_reg.limit_high        <= pwdata;
                REG_LIMIT_LOW:     cfg_reg.limit_low         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAIN_PROP:     prdata = cfg_reg.gain_prop;
            REG_GAIN_INTEGRAL: prdata = cfg_reg.gain_integral;
            REG_GAIN_DERIV:    prdata = cfg_reg.gain_deriv;
            REG_DERIV_COEF:    prdata = {1'b0, cfg_reg.deriv_filter_coef};
            REG_DEADBAND_HIGH: prdata = cfg_reg.deadband_high;
            REG_DEADBAND_LOW:  prdata = cfg_reg.deadband_low;
            REG_LIMIT_HIGH:    prdata = cfg_reg.limit_high;
            REG_LIMIT_LOW:     prdata = cfg_reg.limit_low;
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule

// ===== rtl/pid_controller_deadband_antiwindup_unit.sv =====
// pid controller with dead band, filtered derivative and back-calculation
// each multiply holds its state in the one bit-serial multiplier (start, bit steps, done);
// each add or subtract step and the clamp step take a state of their own; the integral
// and derivative multiplies are skipped when their gains are zero. A new sample is taken
// only in the idle state; a full output register stalls the clamp step. rst_n clears the
// state, the output valid flag and the accumulators
module pid_controller_deadband_antiwindup_unit
    import pdau_pkg::*;
#(
    parameter int SAMPLE_TIME = 6554,
    parameter int FRAC_BITS   = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] target_value,
    input  logic signed [DATA_W-1:0] measured_value,
    input  logic signed [DATA_W-1:0] manual_value,
    input  logic                     manual_mode,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] drive_out,
    output logic signed [DATA_W-1:0] error_value,
    output logic signed [DATA_W-1:0] prop_term,
    output logic signed [DATA_W-1:0] integral_term,
    output logic signed [DATA_W-1:0] deriv_term,
    output logic [1:0]               limit_status,
    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);
    cfg_t cfg;

    pdau_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    localparam logic signed [DATA_W-1:0] TS = DATA_W'(SAMPLE_TIME);

    seq_state_t state_reg, state_next;

    // captured sample
    logic signed [DATA_W-1:0] tv_reg, mv_reg, man_val_reg;
    logic                     man_reg;
    // working values
    logic signed [DATA_W-1:0] e_reg, p_reg, t_reg, d_reg, sw_reg;
    // controller state
    logic signed [DATA_W-1:0] iacc_reg, facc_reg;
    // result register
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] y_out_reg, e_out_reg, p_out_reg, i_out_reg, d_out_reg;
    limit_code_t              st_out_reg;

    logic                     in_xfer, out_xfer, out_free;
    logic                     mul_start, mul_done, issued_reg, mul_state;
    logic signed [DATA_W-1:0] mul_a, mul_b, mul_res;

    pdau_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign out_free = !out_valid_reg || out_ready;

    // combinational arithmetic for the error, clamp and back-calculation steps
    logic signed [DATA_W-1:0] err_sat, y_val, bc_val;
    limit_code_t              status_val;
    logic                     gi_zero, gd_zero;

    assign gi_zero = (cfg.gain_integral == '0);
    assign gd_zero = (cfg.gain_deriv == '0);

    always_comb
    begin
        err_sat = sat34({{2{tv_reg[DATA_W-1]}}, tv_reg} - {{2{mv_reg[DATA_W-1]}}, mv_reg});
        // clamp: inverted limits fall to the low side first
        if (sw_reg <= cfg.limit_low)
        begin
            y_val      = cfg.limit_low;
            status_val = LIM_LOW;
        end
        else if (sw_reg >= cfg.limit_high)
        begin
            y_val      = cfg.limit_high;
            status_val = LIM_HIGH;
        end
        else
        begin
            y_val      = sw_reg;
            status_val = LIM_WITHIN;
        end
        bc_val = sat34({{2{y_val[DATA_W-1]}}, y_val} - {{2{p_reg[DATA_W-1]}}, p_reg}
                       - {{2{d_reg[DATA_W-1]}}, d_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_ERR;
            ST_ERR:   state_next = ST_P;
            ST_P:     if (mul_done) state_next = ST_I1;
            ST_I1:    if (gi_zero) state_next = ST_DM;
                      else if (mul_done) state_next = ST_I2;
            ST_I2:    if (mul_done) state_next = ST_IACC;
            ST_IACC:  state_next = ST_DM;
            ST_DM:    if (gd_zero) state_next = ST_SUM;
                      else if (mul_done) state_next = ST_DDIFF;
            ST_DDIFF: state_next = ST_D;
            ST_D:     if (mul_done) state_next = ST_F;
            ST_F:     if (mul_done) state_next = ST_FACC;
            ST_FACC:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // multiplier control and operand select
    always_comb
    begin
        mul_state = 1'b0;
        mul_a     = e_reg;
        mul_b     = cfg.gain_prop;
        unique case (state_reg)
            ST_P:    mul_state = 1'b1;
            ST_I1:
            begin
                mul_state = !gi_zero;
                mul_b     = cfg.gain_integral;
            end
            ST_I2:
            begin
                mul_state = 1'b1;
                mul_a     = t_reg;
                mul_b     = TS;
            end
            ST_DM:
            begin
                mul_state = !gd_zero;
                mul_b     = cfg.gain_deriv;
            end
            ST_D:
            begin
                mul_state = 1'b1;
                mul_a     = t_reg;
                mul_b     = {1'b0, cfg.deriv_filter_coef};
            end
            ST_F:
            begin
                mul_state = 1'b1;
                mul_a     = d_reg;
                mul_b     = TS;
            end
            default: ;
        endcase
        mul_start = mul_state && !issued_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            iacc_reg      <= '0;
            facc_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
                issued_reg <= 1'b1;
            else if (mul_done)
                issued_reg <= 1'b0;

            if (state_reg == ST_CLAMP && out_free)
                out_valid_reg <= 1'b1;
            else if (out_xfer)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_I1:    if (gi_zero) iacc_reg <= '0;
                ST_IACC:  iacc_reg <= sat34({{2{iacc_reg[DATA_W-1]}}, iacc_reg}
                                            + {{2{t_reg[DATA_W-1]}}, t_reg});
                ST_DM:    if (gd_zero) facc_reg <= '0;
                ST_FACC:  facc_reg <= sat34({{2{facc_reg[DATA_W-1]}}, facc_reg}
                                            + {{2{t_reg[DATA_W-1]}}, t_reg});
                // back-calculation when clamped or in manual mode
                ST_CLAMP: if (out_free && (status_val != LIM_WITHIN || man_reg))
                              iacc_reg <= bc_val;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            tv_reg      <= target_value;
            mv_reg      <= measured_value;
            man_val_reg <= manual_value;
            man_reg     <= manual_mode;
        end
        unique case (state_reg)
            ST_ERR:
                // open dead band zeroes the error
                if (err_sat > cfg.deadband_low && err_sat < cfg.deadband_high)
                    e_reg <= '0;
                else
                    e_reg <= err_sat;
            ST_P:     if (mul_done) p_reg <= mul_res;
            ST_I1, ST_I2, ST_DM, ST_F:
                      if (mul_done) t_reg <= mul_res;
            ST_DDIFF: t_reg <= sat34({{2{t_reg[DATA_W-1]}}, t_reg}
                                     - {{2{facc_reg[DATA_W-1]}}, facc_reg});
            ST_D:     if (mul_done) d_reg <= mul_res;
            ST_SUM:
                if (man_reg)
                    sw_reg <= man_val_reg;
                else
                    sw_reg <= sat34({{2{p_reg[DATA_W-1]}}, p_reg}
                                    + {{2{iacc_reg[DATA_W-1]}}, iacc_reg}
                                    + {{2{d_reg[DATA_W-1]}}, d_reg});
            ST_CLAMP:
                if (out_free)
                begin
                    y_out_reg  <= y_val;
                    e_out_reg  <= e_reg;
                    p_out_reg  <= p_reg;
                    i_out_reg  <= (status_val != LIM_WITHIN || man_reg) ? bc_val : iacc_reg;
                    d_out_reg  <= d_reg;
                    st_out_reg <= status_val;
                end
            default: ;
        endcase
        // a zero derivative gain forces the term to zero for this tick
        if (state_reg == ST_DM && gd_zero)
            d_reg <= '0;
    end

    assign out_valid     = out_valid_reg;
    assign drive_out     = y_out_reg;
    assign error_value   = e_out_reg;
    assign prop_term     = p_out_reg;
    assign integral_term = i_out_reg;
    assign deriv_term    = d_out_reg;
    assign limit_status  = st_out_reg;
endmodule

// ===== rtl/pdau_checker.sv =====
// port-level checks for the pid unit, bound to the top level
// uses pdau_pkg
module pdau_checker
    import pdau_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] drive_out,
    input logic [1:0]        limit_status
);
    // output holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_out))
        else $error("result dropped or changed while stalled");

    // status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> limit_status != 2'd3)
        else $error("bad limit status");

    // a sample keeps the unit busy after it is taken
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken while a sample is in work");

    // input valid stays high while waiting
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input valid dropped");
endmodule

bind pid_controller_deadband_antiwindup_unit pdau_checker u_pdau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_out    (drive_out),
    .limit_status (limit_status)
);
